// ===== src/lcss_pkg.sv =====
package lcss_pkg;

   localparam int IN_W   = 32;
   localparam int MOD_W  = 31;
   localparam int RES_W  = 62;
   localparam int MUL_W  = MOD_W + 2;
   localparam int WIDE_W = RES_W + MOD_W + 1;
   localparam int CNT_W  = $clog2(RES_W);

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_NOSOL = 2'd1;
   localparam logic [1:0] STAT_OVF   = 2'd2;

   typedef struct packed {
      logic signed [IN_W-1:0] coef;
      logic signed [IN_W-1:0] rhs;
      logic [MOD_W-1:0]       modulus;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [RES_W-1:0] residue;
      logic [RES_W-1:0] combined_modulus;
      logic [1:0]       status;
      logic             final_res;
   } rsp_type;

   typedef enum logic [5:0] {
      OP_IDLE, OP_LOAD, OP_FAIL, OP_OUT,
      OP_DIV_A, OP_SET_AR, OP_DIV_B, OP_SET_BR,
      OP_EU_INIT1, OP_EU_INIT2, OP_DIV_EU, OP_EU_MUL, OP_EU_STEP,
      OP_SET_G, OP_DIV_BG, OP_SET_BG, OP_DIV_M2, OP_SET_M2,
      OP_DIV_INV, OP_SET_INV, OP_MUL_R2, OP_DIV_R2, OP_SET_R2,
      OP_DIV_MR, OP_SET_G2, OP_DIV_RM, OP_SET_D, OP_DIV_D, OP_SET_DQ,
      OP_DIV_M1G, OP_SET_M1G, OP_MUL_OV_LO, OP_MUL_OV_HI, OP_SUM_OV, OP_SET_NM,
      OP_DIV_M2G, OP_SET_M2G, OP_DIV_INV2, OP_SET_INV2, OP_MUL_T, OP_DIV_T,
      OP_SET_T, OP_MUL_R_LO, OP_MUL_R_HI, OP_SUM_R, OP_COMMIT
   } op_type;

   typedef enum logic [5:0] {
      S_IDLE, S_CHK, S_DWAIT, S_AR, S_DB, S_BR, S_EU1, S_EU_TEST, S_EU_MUL,
      S_EU_STEP, S_G, S_DBG, S_BG, S_DM2, S_M2, S_DINV, S_INV, S_MR2, S_DR2,
      S_R2, S_DMR, S_EU2, S_G2, S_DRM, S_D, S_DD, S_DQ, S_DM1G, S_M1G,
      S_OVLO, S_OVHI, S_OVSUM, S_OVCHK, S_DM2G, S_M2G, S_DINV2, S_INV2,
      S_MT, S_DT, S_T, S_RLO, S_RHI, S_RSUM, S_COMMIT, S_OUT
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] code;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic r1_zero;
      logic rem_zero;
      logic m_zero;
      logic fail_set;
      logic ovf;
      logic out_free;
   } sts_type;

endpackage

// ===== src/linear_congruence_system_solver_unit.sv =====
// Linear congruence system solver (generalized CRT fold).
// req channel: one word per congruence coef*x = rhs (mod modulus); last
//   closes the system and restarts the fold at residue 0 modulo 1.
// rsp channel: one word per req word with the running residue, combined
//   modulus and status (0 ok, 1 no solution, 2 modulus overflow); final_res
//   echoes last. Failure is sticky up to and including the closing word.
// Only one item is in work at a time. Work is a sequence of restoring
//   divides on one shared divider: about 13 fixed divides plus one per
//   Euclid step in each of two extended Euclid runs (up to ~45 steps each).
//   An item arriving while failed, or with modulus 0, skips the divides and
//   goes straight to the output step.
// req_stall is low only while the controller is idle; the next word is taken
//   while the previous result still sits in the output register.
// rsp_stall holds the output register; the finished item then waits for it
//   before its result is written.
// Reset (synchronous) clears the fold to residue 0, modulus 1, status ok.
module linear_congruence_system_solver_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcss_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcss_pkg::rsp_type rsp
);
   lcss_pkg::cmd_type cmd;
   lcss_pkg::sts_type sts;

   // sequencer: walks the solve and merge steps
   lcss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: divider, multiplier, fold state, output word
   lcss_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .cmd       (cmd),
      .sts       (sts)
   );
endmodule

// ===== src/lcss_div.sv =====
// restoring divider, one quotient bit per cycle
module lcss_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lcss_pkg::RES_W-1:0] dividend,
   input  logic [lcss_pkg::RES_W-1:0] divisor,
   output logic [lcss_pkg::RES_W-1:0] quo,
   output logic [lcss_pkg::RES_W-1:0] rem,
   output logic                       done
);
   localparam int W = lcss_pkg::RES_W;
   localparam logic [lcss_pkg::CNT_W-1:0] LAST_CNT = lcss_pkg::CNT_W'(W - 1);

   logic                       busy_ff, done_ff;
   logic [lcss_pkg::CNT_W-1:0] cnt_ff;
   logic [W-1:0]               quo_ff, rem_ff, dvs_ff;
   logic [W:0]                 trial, diff;
   logic                       ge;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == LAST_CNT);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT)
               busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[W-2:0], ge};
         rem_ff <= ge ? diff[W-1:0] : trial[W-1:0];
      end
   end

   assign quo  = quo_ff;
   assign rem  = rem_ff;
   assign done = done_ff;
endmodule

// ===== src/lcss_datapath.sv =====
module lcss_datapath (
   input  logic              clock,
   input  logic              reset,
   input  lcss_pkg::req_type req,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output lcss_pkg::rsp_type rsp,
   input  lcss_pkg::cmd_type cmd,
   output lcss_pkg::sts_type sts
);
   localparam int IW = lcss_pkg::IN_W;
   localparam int MW = lcss_pkg::MOD_W;
   localparam int RW = lcss_pkg::RES_W;
   localparam int UW = lcss_pkg::MUL_W;
   localparam int XW = lcss_pkg::WIDE_W;

   logic signed [IW-1:0] a_ff, b_ff;
   logic [MW-1:0]        m_ff;
   logic                 last_ff;
   logic [RW-1:0]        acc_r_ff, acc_m_ff;
   logic [1:0]           fail_ff;
   logic [MW-1:0]        ar_ff, br_ff, g_ff, bg_ff, m2_ff, r2_ff, g2_ff, dq_ff;
   logic [MW-1:0]        m2g_ff, inv_ff, t_ff, d_ff;
   logic [RW-1:0]        m1g_ff, nm_ff, p_ff, plo_ff, phi_ff;
   logic [MW-1:0]        e_r0_ff, e_r1_ff;
   logic signed [IW-1:0] e_t0_ff, e_t1_ff;
   logic [XW-1:0]        wide_ff;
   lcss_pkg::rsp_type    rsp_ff;
   logic                 rsp_valid_ff;

   logic                 div_start, div_done;
   logic [RW-1:0]        dvd, dvs, div_quo, div_rem;
   logic signed [UW-1:0] mul_a, mul_b;
   logic signed [2*UW-1:0] prod;
   logic [XW-1:0]        wide_in, sum_add;
   logic [IW-1:0]        abs_a, abs_b, abs_t0;
   logic [MW-1:0]        rem31, d_calc;
   logic [MW:0]          d_wrap;

   function automatic logic [MW-1:0] fix_neg(input logic [MW-1:0] r, input logic neg,
                                             input logic [MW-1:0] md);
      fix_neg = (neg && (r != '0)) ? md - r : r;
   endfunction

   assign abs_a  = a_ff[IW-1] ? (~a_ff + 1'b1) : a_ff;
   assign abs_b  = b_ff[IW-1] ? (~b_ff + 1'b1) : b_ff;
   assign abs_t0 = e_t0_ff[IW-1] ? (~e_t0_ff + 1'b1) : e_t0_ff;
   assign rem31  = div_rem[MW-1:0];
   assign d_wrap = {1'b0, r2_ff} + {1'b0, m2_ff} - {1'b0, rem31};
   assign d_calc = (r2_ff >= rem31) ? r2_ff - rem31 : d_wrap[MW-1:0];

   // divider operand select
   always_comb begin
      div_start = 1'b1;
      dvd       = '0;
      dvs       = '0;
      case (cmd.op)
         lcss_pkg::OP_DIV_A:    begin dvd = RW'(abs_a);  dvs = RW'(m_ff);   end
         lcss_pkg::OP_DIV_B:    begin dvd = RW'(abs_b);  dvs = RW'(m_ff);   end
         lcss_pkg::OP_DIV_EU:   begin dvd = RW'(e_r0_ff); dvs = RW'(e_r1_ff); end
         lcss_pkg::OP_DIV_BG:   begin dvd = RW'(br_ff);  dvs = RW'(g_ff);   end
         lcss_pkg::OP_DIV_M2:   begin dvd = RW'(m_ff);   dvs = RW'(g_ff);   end
         lcss_pkg::OP_DIV_INV:  begin dvd = RW'(abs_t0); dvs = RW'(m2_ff);  end
         lcss_pkg::OP_DIV_R2:   begin dvd = p_ff;        dvs = RW'(m2_ff);  end
         lcss_pkg::OP_DIV_MR:   begin dvd = acc_m_ff;    dvs = RW'(m2_ff);  end
         lcss_pkg::OP_DIV_RM:   begin dvd = acc_r_ff;    dvs = RW'(m2_ff);  end
         lcss_pkg::OP_DIV_D:    begin dvd = RW'(d_ff);   dvs = RW'(g2_ff);  end
         lcss_pkg::OP_DIV_M1G:  begin dvd = acc_m_ff;    dvs = RW'(g2_ff);  end
         lcss_pkg::OP_DIV_M2G:  begin dvd = RW'(m2_ff);  dvs = RW'(g2_ff);  end
         lcss_pkg::OP_DIV_INV2: begin dvd = RW'(abs_t0); dvs = RW'(m2g_ff); end
         lcss_pkg::OP_DIV_T:    begin dvd = p_ff;        dvs = RW'(m2g_ff); end
         default:               div_start = 1'b0;
      endcase
   end

   // shared multiplier, 33x33 signed
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         lcss_pkg::OP_EU_MUL: begin
            mul_a = UW'(div_quo[MW-1:0]);
            mul_b = UW'(e_t1_ff);
         end
         lcss_pkg::OP_MUL_R2:    begin mul_a = UW'(bg_ff); mul_b = UW'(inv_ff); end
         lcss_pkg::OP_MUL_OV_LO: begin mul_a = UW'(m1g_ff[MW-1:0]); mul_b = UW'(m2_ff); end
         lcss_pkg::OP_MUL_OV_HI: begin mul_a = UW'(m1g_ff[RW-1:MW]); mul_b = UW'(m2_ff); end
         lcss_pkg::OP_MUL_T:     begin mul_a = UW'(dq_ff); mul_b = UW'(inv_ff); end
         lcss_pkg::OP_MUL_R_LO:  begin mul_a = UW'(acc_m_ff[MW-1:0]); mul_b = UW'(t_ff); end
         lcss_pkg::OP_MUL_R_HI:  begin mul_a = UW'(acc_m_ff[RW-1:MW]); mul_b = UW'(t_ff); end
         default: ;
      endcase
   end
   // signed extension of t1 happens through UW'(e_t1_ff) above
   assign prod = mul_a * mul_b;

   assign sum_add = (cmd.op == lcss_pkg::OP_SUM_R) ? XW'(acc_r_ff) : '0;
   assign wide_in = XW'({phi_ff, {MW{1'b0}}}) + XW'(plo_ff) + sum_add;

   lcss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .quo      (div_quo),
      .rem      (div_rem),
      .done     (div_done)
   );

   // fold state and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_r_ff     <= '0;
         acc_m_ff     <= RW'(1);
         fail_ff      <= lcss_pkg::STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == lcss_pkg::OP_OUT)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         case (cmd.op)
            lcss_pkg::OP_FAIL: fail_ff <= cmd.code;
            lcss_pkg::OP_COMMIT: begin
               acc_r_ff <= wide_ff[RW-1:0];
               acc_m_ff <= nm_ff;
            end
            lcss_pkg::OP_OUT: begin
               if (last_ff) begin
                  acc_r_ff <= '0;
                  acc_m_ff <= RW'(1);
                  fail_ff  <= lcss_pkg::STAT_OK;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         lcss_pkg::OP_LOAD: begin
            a_ff    <= req.coef;
            b_ff    <= req.rhs;
            m_ff    <= req.modulus;
            last_ff <= req.last;
         end
         lcss_pkg::OP_SET_AR: ar_ff <= fix_neg(rem31, a_ff[IW-1], m_ff);
         lcss_pkg::OP_SET_BR: br_ff <= fix_neg(rem31, b_ff[IW-1], m_ff);
         lcss_pkg::OP_EU_INIT1: begin
            e_r0_ff <= m_ff;
            e_r1_ff <= ar_ff;
            e_t0_ff <= '0;
            e_t1_ff <= IW'(1);
         end
         lcss_pkg::OP_EU_INIT2: begin
            e_r0_ff <= m2_ff;
            e_r1_ff <= rem31;
            e_t0_ff <= '0;
            e_t1_ff <= IW'(1);
         end
         lcss_pkg::OP_EU_STEP: begin
            e_r0_ff <= e_r1_ff;
            e_r1_ff <= rem31;
            e_t0_ff <= e_t1_ff;
            e_t1_ff <= e_t0_ff - $signed(p_ff[IW-1:0]);
         end
         lcss_pkg::OP_SET_G:    g_ff   <= e_r0_ff;
         lcss_pkg::OP_SET_BG:   bg_ff  <= div_quo[MW-1:0];
         lcss_pkg::OP_SET_M2:   m2_ff  <= div_quo[MW-1:0];
         lcss_pkg::OP_SET_INV:  inv_ff <= fix_neg(rem31, e_t0_ff[IW-1], m2_ff);
         lcss_pkg::OP_SET_R2:   r2_ff  <= rem31;
         lcss_pkg::OP_SET_G2:   g2_ff  <= e_r0_ff;
         lcss_pkg::OP_SET_D:    d_ff   <= d_calc;
         lcss_pkg::OP_SET_DQ:   dq_ff  <= div_quo[MW-1:0];
         lcss_pkg::OP_SET_M1G:  m1g_ff <= div_quo;
         lcss_pkg::OP_SET_NM:   nm_ff  <= wide_ff[RW-1:0];
         lcss_pkg::OP_SET_M2G:  m2g_ff <= div_quo[MW-1:0];
         lcss_pkg::OP_SET_INV2: inv_ff <= fix_neg(rem31, e_t0_ff[IW-1], m2g_ff);
         lcss_pkg::OP_SET_T:    t_ff   <= rem31;
         lcss_pkg::OP_EU_MUL, lcss_pkg::OP_MUL_R2, lcss_pkg::OP_MUL_T:
            p_ff <= prod[RW-1:0];
         lcss_pkg::OP_MUL_OV_LO, lcss_pkg::OP_MUL_R_LO: plo_ff <= prod[RW-1:0];
         lcss_pkg::OP_MUL_OV_HI, lcss_pkg::OP_MUL_R_HI: phi_ff <= prod[RW-1:0];
         lcss_pkg::OP_SUM_OV, lcss_pkg::OP_SUM_R: wide_ff <= wide_in;
         lcss_pkg::OP_OUT: begin
            rsp_ff.residue          <= (fail_ff == lcss_pkg::STAT_OK) ? acc_r_ff : '0;
            rsp_ff.combined_modulus <= (fail_ff == lcss_pkg::STAT_OK) ? acc_m_ff : '0;
            rsp_ff.status           <= fail_ff;
            rsp_ff.final_res        <= last_ff;
         end
         default: ;
      endcase
   end

   assign sts.div_done = div_done;
   assign sts.r1_zero  = (e_r1_ff == '0);
   assign sts.rem_zero = (div_rem == '0);
   assign sts.m_zero   = (m_ff == '0);
   assign sts.fail_set = (fail_ff != lcss_pkg::STAT_OK);
   assign sts.ovf      = (wide_ff[XW-1:RW] != '0);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule

// ===== src/lcss_ctrl.sv =====
module lcss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output lcss_pkg::cmd_type cmd,
   input  lcss_pkg::sts_type sts
);
   lcss_pkg::state_type state_ff, state_in;
   lcss_pkg::state_type div_ret_ff, div_ret_in;
   lcss_pkg::state_type eu_ret_ff, eu_ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lcss_pkg::S_IDLE;
         div_ret_ff <= lcss_pkg::S_IDLE;
         eu_ret_ff  <= lcss_pkg::S_IDLE;
      end else begin
         state_ff   <= state_in;
         div_ret_ff <= div_ret_in;
         eu_ret_ff  <= eu_ret_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_ret_in = div_ret_ff;
      eu_ret_in  = eu_ret_ff;
      cmd.op     = lcss_pkg::OP_IDLE;
      cmd.code   = lcss_pkg::STAT_OK;
      req_stall  = 1'b1;
      case (state_ff)
         lcss_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = lcss_pkg::OP_LOAD;
               state_in = lcss_pkg::S_CHK;
            end
         end
         lcss_pkg::S_CHK: begin
            if (sts.fail_set) begin
               state_in = lcss_pkg::S_OUT;
            end else if (sts.m_zero) begin
               cmd.op   = lcss_pkg::OP_FAIL;
               cmd.code = lcss_pkg::STAT_NOSOL;
               state_in = lcss_pkg::S_OUT;
            end else begin
               cmd.op     = lcss_pkg::OP_DIV_A;
               div_ret_in = lcss_pkg::S_AR;
               state_in   = lcss_pkg::S_DWAIT;
            end
         end
         lcss_pkg::S_DWAIT: if (sts.div_done) state_in = div_ret_ff;
         lcss_pkg::S_AR: begin cmd.op = lcss_pkg::OP_SET_AR; state_in = lcss_pkg::S_DB; end
         lcss_pkg::S_DB: begin
            cmd.op = lcss_pkg::OP_DIV_B; div_ret_in = lcss_pkg::S_BR;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_BR: begin cmd.op = lcss_pkg::OP_SET_BR; state_in = lcss_pkg::S_EU1; end
         lcss_pkg::S_EU1: begin
            cmd.op = lcss_pkg::OP_EU_INIT1; eu_ret_in = lcss_pkg::S_G;
            state_in = lcss_pkg::S_EU_TEST;
         end
         lcss_pkg::S_EU_TEST: begin
            if (sts.r1_zero) begin
               state_in = eu_ret_ff;
            end else begin
               cmd.op = lcss_pkg::OP_DIV_EU; div_ret_in = lcss_pkg::S_EU_MUL;
               state_in = lcss_pkg::S_DWAIT;
            end
         end
         lcss_pkg::S_EU_MUL: begin cmd.op = lcss_pkg::OP_EU_MUL; state_in = lcss_pkg::S_EU_STEP; end
         lcss_pkg::S_EU_STEP: begin
            cmd.op = lcss_pkg::OP_EU_STEP; state_in = lcss_pkg::S_EU_TEST;
         end
         lcss_pkg::S_G: begin cmd.op = lcss_pkg::OP_SET_G; state_in = lcss_pkg::S_DBG; end
         lcss_pkg::S_DBG: begin
            cmd.op = lcss_pkg::OP_DIV_BG; div_ret_in = lcss_pkg::S_BG;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_BG: begin
            if (!sts.rem_zero) begin
               cmd.op = lcss_pkg::OP_FAIL; cmd.code = lcss_pkg::STAT_NOSOL;
               state_in = lcss_pkg::S_OUT;
            end else begin
               cmd.op = lcss_pkg::OP_SET_BG; state_in = lcss_pkg::S_DM2;
            end
         end
         lcss_pkg::S_DM2: begin
            cmd.op = lcss_pkg::OP_DIV_M2; div_ret_in = lcss_pkg::S_M2;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_M2: begin cmd.op = lcss_pkg::OP_SET_M2; state_in = lcss_pkg::S_DINV; end
         lcss_pkg::S_DINV: begin
            cmd.op = lcss_pkg::OP_DIV_INV; div_ret_in = lcss_pkg::S_INV;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_INV: begin cmd.op = lcss_pkg::OP_SET_INV; state_in = lcss_pkg::S_MR2; end
         lcss_pkg::S_MR2: begin cmd.op = lcss_pkg::OP_MUL_R2; state_in = lcss_pkg::S_DR2; end
         lcss_pkg::S_DR2: begin
            cmd.op = lcss_pkg::OP_DIV_R2; div_ret_in = lcss_pkg::S_R2;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_R2: begin cmd.op = lcss_pkg::OP_SET_R2; state_in = lcss_pkg::S_DMR; end
         lcss_pkg::S_DMR: begin
            cmd.op = lcss_pkg::OP_DIV_MR; div_ret_in = lcss_pkg::S_EU2;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_EU2: begin
            cmd.op = lcss_pkg::OP_EU_INIT2; eu_ret_in = lcss_pkg::S_G2;
            state_in = lcss_pkg::S_EU_TEST;
         end
         lcss_pkg::S_G2: begin cmd.op = lcss_pkg::OP_SET_G2; state_in = lcss_pkg::S_DRM; end
         lcss_pkg::S_DRM: begin
            cmd.op = lcss_pkg::OP_DIV_RM; div_ret_in = lcss_pkg::S_D;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_D: begin cmd.op = lcss_pkg::OP_SET_D; state_in = lcss_pkg::S_DD; end
         lcss_pkg::S_DD: begin
            cmd.op = lcss_pkg::OP_DIV_D; div_ret_in = lcss_pkg::S_DQ;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_DQ: begin
            if (!sts.rem_zero) begin
               cmd.op = lcss_pkg::OP_FAIL; cmd.code = lcss_pkg::STAT_NOSOL;
               state_in = lcss_pkg::S_OUT;
            end else begin
               cmd.op = lcss_pkg::OP_SET_DQ; state_in = lcss_pkg::S_DM1G;
            end
         end
         lcss_pkg::S_DM1G: begin
            cmd.op = lcss_pkg::OP_DIV_M1G; div_ret_in = lcss_pkg::S_M1G;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_M1G: begin cmd.op = lcss_pkg::OP_SET_M1G; state_in = lcss_pkg::S_OVLO; end
         lcss_pkg::S_OVLO: begin cmd.op = lcss_pkg::OP_MUL_OV_LO; state_in = lcss_pkg::S_OVHI; end
         lcss_pkg::S_OVHI: begin cmd.op = lcss_pkg::OP_MUL_OV_HI; state_in = lcss_pkg::S_OVSUM; end
         lcss_pkg::S_OVSUM: begin cmd.op = lcss_pkg::OP_SUM_OV; state_in = lcss_pkg::S_OVCHK; end
         lcss_pkg::S_OVCHK: begin
            if (sts.ovf) begin
               cmd.op = lcss_pkg::OP_FAIL; cmd.code = lcss_pkg::STAT_OVF;
               state_in = lcss_pkg::S_OUT;
            end else begin
               cmd.op = lcss_pkg::OP_SET_NM; state_in = lcss_pkg::S_DM2G;
            end
         end
         lcss_pkg::S_DM2G: begin
            cmd.op = lcss_pkg::OP_DIV_M2G; div_ret_in = lcss_pkg::S_M2G;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_M2G: begin cmd.op = lcss_pkg::OP_SET_M2G; state_in = lcss_pkg::S_DINV2; end
         lcss_pkg::S_DINV2: begin
            cmd.op = lcss_pkg::OP_DIV_INV2; div_ret_in = lcss_pkg::S_INV2;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_INV2: begin cmd.op = lcss_pkg::OP_SET_INV2; state_in = lcss_pkg::S_MT; end
         lcss_pkg::S_MT: begin cmd.op = lcss_pkg::OP_MUL_T; state_in = lcss_pkg::S_DT; end
         lcss_pkg::S_DT: begin
            cmd.op = lcss_pkg::OP_DIV_T; div_ret_in = lcss_pkg::S_T;
            state_in = lcss_pkg::S_DWAIT;
         end
         lcss_pkg::S_T: begin cmd.op = lcss_pkg::OP_SET_T; state_in = lcss_pkg::S_RLO; end
         lcss_pkg::S_RLO: begin cmd.op = lcss_pkg::OP_MUL_R_LO; state_in = lcss_pkg::S_RHI; end
         lcss_pkg::S_RHI: begin cmd.op = lcss_pkg::OP_MUL_R_HI; state_in = lcss_pkg::S_RSUM; end
         lcss_pkg::S_RSUM: begin cmd.op = lcss_pkg::OP_SUM_R; state_in = lcss_pkg::S_COMMIT; end
         lcss_pkg::S_COMMIT: begin cmd.op = lcss_pkg::OP_COMMIT; state_in = lcss_pkg::S_OUT; end
         lcss_pkg::S_OUT: begin
            if (sts.out_free) begin
               cmd.op = lcss_pkg::OP_OUT; state_in = lcss_pkg::S_IDLE;
            end
         end
         default: state_in = lcss_pkg::S_IDLE;
      endcase
   end
endmodule

// ===== src/lcss_checker.sv =====
module lcss_sva (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lcss_pkg::rsp_type rsp
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("rsp word dropped or changed under stall");

   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req word taken while busy");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status == lcss_pkg::STAT_OK || rsp.status == lcss_pkg::STAT_NOSOL
                     || rsp.status == lcss_pkg::STAT_OVF))
      else $error("bad status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != lcss_pkg::STAT_OK |->
         rsp.residue == '0 && rsp.combined_modulus == '0)
      else $error("failed word carries data");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == lcss_pkg::STAT_OK |->
         rsp.residue < rsp.combined_modulus)
      else $error("residue not below modulus");
endmodule

bind linear_congruence_system_solver_unit lcss_sva u_lcss_sva (.*);
